@@ rtl/ilir_pkg.sv @@
package ilir_pkg;

  localparam int unsigned POS_W    = 5;
  localparam int unsigned RESULT_W = 32;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_GET    = 3'd1,
    OP_SET    = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_WRITE  = 2'd1,
    CM_INSERT = 2'd2,
    CM_REMOVE = 2'd3
  } cell_mode_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [POS_W-1:0]     position;
    logic [RESULT_W-1:0]  item_value;
  } cmd_t;

  typedef struct packed {
    logic [RESULT_W-1:0]  result_value;
    status_e              status;
    logic [COUNT_W-1:0]   entry_count;
    logic                 not_empty;
  } result_t;

endpackage

@@ rtl/ilir_cell.sv @@
module ilir_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX_W       = 5,
  parameter int unsigned INDEX       = 0
) (
  input  logic                    clk_i,
  input  ilir_pkg::cell_mode_e    mode_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic [VALUE_WIDTH-1:0]  wr_value_i,
  input  logic [VALUE_WIDTH-1:0]  lower_i,
  input  logic [VALUE_WIDTH-1:0]  upper_i,
  output logic [VALUE_WIDTH-1:0]  data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [VALUE_WIDTH-1:0] data_q, data_d;
  logic                   hit;
  logic                   above;

  assign hit   = (idx_i == MyIdx);
  assign above = (MyIdx > idx_i);

  always_comb begin
    data_d = data_q;
    case (mode_i)
      ilir_pkg::CM_WRITE: begin
        if (hit) data_d = wr_value_i;
      end
      ilir_pkg::CM_INSERT: begin
        // Cells above the target take their lower neighbor, opening the gap.
        if (hit) begin
          data_d = wr_value_i;
        end else if (above) begin
          data_d = lower_i;
        end
      end
      ilir_pkg::CM_REMOVE: begin
        if (hit || above) data_d = upper_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/ilir_ctrl.sv @@
module ilir_ctrl #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX_W       = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  ilir_pkg::cmd_t          cmd_i,
  input  logic [VALUE_WIDTH-1:0]  rd_data_i,
  output ilir_pkg::cell_mode_e    mode_o,
  output logic [IDX_W-1:0]        idx_o,
  output logic [VALUE_WIDTH-1:0]  wr_value_o,
  output logic                    strobe_o,
  output ilir_pkg::result_t       result_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > ilir_pkg::POS_W) ? CNT_W : ilir_pkg::POS_W;

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    strobe_q;
  ilir_pkg::result_t       result_q, result_d;
  logic                    in_range;
  logic                    full;
  logic [VALUE_WIDTH-1:0]  value;

  assign value    = VALUE_WIDTH'(cmd_i.item_value);
  assign in_range = (CMP_W'(cmd_i.position) < CMP_W'(count_q));
  assign full     = (count_q == CNT_W'(CAPACITY));

  // Cell commands and the next count.
  always_comb begin
    mode_o     = ilir_pkg::CM_HOLD;
    idx_o      = IDX_W'(cmd_i.position);
    wr_value_o = value;
    count_d    = count_q;
    if (accept_i) begin
      case (cmd_i.opcode)
        ilir_pkg::OP_APPEND: begin
          if (!full) begin
            mode_o  = ilir_pkg::CM_WRITE;
            idx_o   = IDX_W'(count_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        ilir_pkg::OP_SET: begin
          if (in_range) mode_o = ilir_pkg::CM_WRITE;
        end
        ilir_pkg::OP_INSERT: begin
          if (in_range && !full) begin
            mode_o  = ilir_pkg::CM_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        ilir_pkg::OP_REMOVE: begin
          if (in_range) begin
            mode_o  = ilir_pkg::CM_REMOVE;
            count_d = count_q - CNT_W'(1);
          end
        end
        default: mode_o = ilir_pkg::CM_HOLD;
      endcase
    end
  end

  // Result of the command, registered for one strobe cycle.
  always_comb begin
    result_d.result_value = '0;
    result_d.status       = ilir_pkg::ST_OK;
    result_d.entry_count  = ilir_pkg::COUNT_W'(count_d);
    result_d.not_empty    = (count_d != '0);
    case (cmd_i.opcode)
      ilir_pkg::OP_APPEND: begin
        if (full) begin
          result_d.status = ilir_pkg::ST_FULL;
        end else begin
          result_d.result_value = ilir_pkg::RESULT_W'(value);
        end
      end
      ilir_pkg::OP_GET, ilir_pkg::OP_REMOVE: begin
        if (!in_range) begin
          result_d.status = ilir_pkg::ST_RANGE;
        end else begin
          result_d.result_value = ilir_pkg::RESULT_W'(rd_data_i);
        end
      end
      ilir_pkg::OP_SET: begin
        if (!in_range) begin
          result_d.status = ilir_pkg::ST_RANGE;
        end else begin
          result_d.result_value = ilir_pkg::RESULT_W'(value);
        end
      end
      ilir_pkg::OP_INSERT: begin
        if (!in_range) begin
          result_d.status = ilir_pkg::ST_RANGE;
        end else if (full) begin
          result_d.status = ilir_pkg::ST_FULL;
        end else begin
          result_d.result_value = ilir_pkg::RESULT_W'(value);
        end
      end
      default: result_d.result_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      strobe_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) result_q <= result_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> strobe_q)
    else $error("accepted command gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> !strobe_q)
    else $error("result without a command");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cmd_i.opcode == ilir_pkg::OP_REMOVE && in_range
    |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not shrink the list");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && result_q.status != ilir_pkg::ST_OK |-> result_q.result_value == '0)
    else $error("error result carries a value");

endmodule

@@ rtl/indexed_list_insert_remove_top.sv @@
// Ordered list of CAPACITY entries with one command per transfer: append, get, set,
// insert and remove. A command is taken at every clock edge with start high; busy is
// always low, so a new command may follow in the very next cycle. Each command gives
// exactly one result, shown on result_o with strobe_o high for the single cycle after
// the command, and the receiver must take it then. The entries live in a chain of cells,
// one entry per cell; on an insert or remove each cell above the target, and on a remove
// the target too, loads from its neighbor at once. No clearing pass follows reset.
module indexed_list_insert_remove_top #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ilir_pkg::cmd_t      cmd_i,
  output logic                strobe_o,
  output ilir_pkg::result_t   result_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SEL_W = (IDX_W > ilir_pkg::POS_W) ? IDX_W : ilir_pkg::POS_W;

  logic                    accept;
  ilir_pkg::cell_mode_e    mode;
  logic [IDX_W-1:0]        idx;
  logic [VALUE_WIDTH-1:0]  wr_value;
  logic [VALUE_WIDTH-1:0]  cell_data [CAPACITY];
  logic [VALUE_WIDTH-1:0]  cell_hit  [CAPACITY];
  logic [VALUE_WIDTH-1:0]  rd_data;
  logic [SEL_W-1:0]        pos_sel;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_sel = SEL_W'(cmd_i.position);

  ilir_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .rd_data_i  (rd_data),
    .mode_o     (mode),
    .idx_o      (idx),
    .wr_value_o (wr_value),
    .strobe_o   (strobe_o),
    .result_o   (result_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lower;
    logic [VALUE_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end

    // The top cell only takes this on a remove, where it falls above the new count.
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    ilir_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .mode_i     (mode),
      .idx_i      (idx),
      .wr_value_i (wr_value),
      .lower_i    (lower),
      .upper_i    (upper),
      .data_o     (cell_data[i])
    );

    assign cell_hit[i] = (pos_sel == SEL_W'(i)) ? cell_data[i] : '0;
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_hit[k];
    end
  end

endmodule

@@ tb/sv/tb_indexed_list_insert_remove_top.sv @@
module tb_indexed_list_insert_remove_top;
  import ilir_pkg::*;

  localparam int unsigned CAP         = 32;
  localparam int unsigned CYCLE_LIMIT = 20000;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  cmd_t    cmd_i  = '0;
  logic    strobe_o;
  result_t result_o;

  // List contents as the block should hold them.
  logic [RESULT_W-1:0] list_entries [CAP];
  int unsigned         list_count   = 0;
  result_t             expected_results [$];

  // Occupancy as the stimulus side sees it, so that positions can be aimed.
  int unsigned stim_count = 0;
  bit          idle_en    = 1'b1;

  int unsigned mismatches    = 0;
  int unsigned checked       = 0;
  int unsigned accepted      = 0;
  int unsigned range_errors  = 0;
  int unsigned full_rejects  = 0;
  int unsigned unused_ops    = 0;
  int unsigned peak_count    = 0;
  int unsigned cycle_count   = 0;

  indexed_list_insert_remove_top #(
    .CAPACITY   (CAP),
    .VALUE_WIDTH(32)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic result_t predict_list_op(cmd_t c);
    result_t r;
    r.result_value = '0;
    r.status       = ST_OK;
    case (c.opcode)
      OP_APPEND: begin
        if (list_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_count] = c.item_value;
          list_count++;
          r.result_value = c.item_value;
        end
      end
      OP_GET: begin
        if (c.position >= list_count) r.status = ST_RANGE;
        else r.result_value = list_entries[c.position];
      end
      OP_SET: begin
        if (c.position >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          list_entries[c.position] = c.item_value;
          r.result_value = c.item_value;
        end
      end
      OP_INSERT: begin
        // The index is checked first, so a full list still reports a bad index.
        if (c.position >= list_count) begin
          r.status = ST_RANGE;
        end else if (list_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned i = list_count; i > c.position; i--)
            list_entries[i] = list_entries[i-1];
          list_entries[c.position] = c.item_value;
          list_count++;
          r.result_value = c.item_value;
        end
      end
      OP_REMOVE: begin
        if (c.position >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          r.result_value = list_entries[c.position];
          for (int unsigned i = c.position; i + 1 < list_count; i++)
            list_entries[i] = list_entries[i+1];
          list_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(list_count);
    r.not_empty   = (list_count != 0);
    return r;
  endfunction

  // The result of a command accepted at one edge is taken at the next, so the
  // check runs before the new expectation is queued.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (strobe_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("Result with no command outstanding: %h", result_o);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        checked++;
        if (result_o.result_value !== exp_r.result_value) begin
          $error("result_value: expected %h, got %h", exp_r.result_value,
                 result_o.result_value);
          mismatches++;
        end
        if (result_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, result_o.status);
          mismatches++;
        end
        if (result_o.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 result_o.entry_count);
          mismatches++;
        end
        if (result_o.not_empty !== exp_r.not_empty) begin
          $error("not_empty: expected %0d, got %0d", exp_r.not_empty, result_o.not_empty);
          mismatches++;
        end
      end
    end
    if (rst_ni && start && busy === 1'b0) begin
      exp_r = predict_list_op(cmd_i);
      expected_results.push_back(exp_r);
      accepted++;
      if (exp_r.status == ST_RANGE) range_errors++;
      if (exp_r.status == ST_FULL) full_rejects++;
      if (cmd_i.opcode > OP_REMOVE) unused_ops++;
      if (list_count > peak_count) peak_count = list_count;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_cmd(input opcode_e op, input logic [POS_W-1:0] pos,
                          input logic [RESULT_W-1:0] val);
    cmd_t c;
    c.opcode     = op;
    c.position   = pos;
    c.item_value = val;
    if (idle_en && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    case (op)
      OP_APPEND: if (stim_count < CAP) stim_count++;
      OP_INSERT: if (pos < stim_count && stim_count < CAP) stim_count++;
      OP_REMOVE: if (pos < stim_count) stim_count--;
      default: ;
    endcase
  endtask

  // The weights are percentages for growing (append, insert) and shrinking (remove);
  // what is left goes to get and set, with a few unused opcodes mixed in.
  task automatic send_random(input int unsigned grow_w, input int unsigned shrink_w);
    int unsigned         r;
    opcode_e             op;
    logic [POS_W-1:0]    pos;
    logic [RESULT_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 3) op = opcode_e'(3'($urandom_range(5, 7)));
    else if (r < 3 + grow_w / 2) op = OP_APPEND;
    else if (r < 3 + grow_w) op = OP_INSERT;
    else if (r < 3 + grow_w + shrink_w) op = OP_REMOVE;
    else if (r[0]) op = OP_GET;
    else op = OP_SET;
    if (stim_count != 0 && $urandom_range(0, 99) < 85)
      pos = POS_W'($urandom_range(0, stim_count - 1));
    else
      pos = POS_W'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    send_cmd(op, pos, val);
  endtask

  task automatic test_directed();
    send_cmd(OP_GET,    5'd0,  32'h1111_1111);
    send_cmd(OP_REMOVE, 5'd0,  32'h0);
    send_cmd(OP_SET,    5'd0,  32'h2222_2222);
    send_cmd(OP_INSERT, 5'd0,  32'h3333_3333);
    send_cmd(OP_APPEND, 5'd31, 32'hFFFF_FFFF);
    send_cmd(OP_APPEND, 5'd0,  32'h0000_0000);
    send_cmd(OP_APPEND, 5'd7,  32'h5A5A_A5A5);
    send_cmd(OP_GET,    5'd2,  32'h0);
    send_cmd(OP_SET,    5'd1,  32'h1234_5678);
    send_cmd(OP_INSERT, 5'd0,  32'hC0DE_F00D);
    send_cmd(OP_INSERT, 5'd3,  32'h0000_0001);
    send_cmd(OP_GET,    5'd4,  32'h0);
    send_cmd(OP_REMOVE, 5'd0,  32'h0);
    send_cmd(OP_REMOVE, 5'd3,  32'h0);
    send_cmd(OP_GET,    5'd31, 32'h0);
    send_cmd(opcode_e'(3'd5), 5'd31, 32'hFFFF_FFFF);
    send_cmd(opcode_e'(3'd6), 5'd0,  32'hAAAA_5555);
    send_cmd(opcode_e'(3'd7), 5'd1,  32'h8000_0000);
    send_cmd(OP_REMOVE, 5'd1,  32'h0);
    send_cmd(OP_GET,    5'd0,  32'h0);
    send_cmd(OP_GET,    5'd1,  32'h0);
    // Insert at the position just past the end is an index error, not an append.
    send_cmd(OP_INSERT, 5'd2,  32'h7777_7777);
    send_cmd(OP_SET,    5'd31, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    int unsigned n;
    for (int round = 0; round < 2; round++) begin
      n = 0;
      while (stim_count < CAP && n < 150) begin
        send_random(70, 5);
        n++;
      end
      repeat (6) send_random(70, 5);
      n = 0;
      while (stim_count > 0 && n < 150) begin
        send_random(5, 75);
        n++;
      end
      repeat (4) send_random(5, 75);
    end
  endtask

  task automatic test_random_mix();
    idle_en = 1'b0;
    repeat (100) send_random(30, 25);
    idle_en = 1'b1;
    repeat (100) send_random(30, 30);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    $display("Checked %0d results for %0d commands; the list reached %0d of %0d entries.",
             checked, accepted, peak_count, CAP);
    $display("Seen: %0d index errors, %0d full-list rejections, %0d unused opcodes.",
             range_errors, full_rejects, unused_ops);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ indexed_list_insert_remove_top.f @@
rtl/ilir_pkg.sv
rtl/ilir_cell.sv
rtl/ilir_ctrl.sv
rtl/indexed_list_insert_remove_top.sv
tb/sv/tb_indexed_list_insert_remove_top.sv
